// ----- src/tcch_pkg.sv -----
// Shared types, constants and the arctangent table for the compass heading unit.
package tcch_pkg;

    // CORDIC iteration count, limited to the table length
    localparam int CORDIC_ITERATIONS = 16;
    localparam int ATAN_LEN          = 24;
    localparam int ITERS = (CORDIC_ITERATIONS > ATAN_LEN) ? ATAN_LEN : CORDIC_ITERATIONS;

    localparam logic signed [31:0] GAIN_Q30     = 32'sd652032874;
    localparam logic [31:0]        HALF_TURN    = 32'h8000_0000;
    localparam logic [31:0]        QUARTER_TURN = 32'h4000_0000;

    // centidegrees to binary angle: r*2^32/36000 = r*BAM_WHOLE + (r*1456+1125)/2250
    localparam logic [16:0] BAM_WHOLE    = 17'd119304;
    localparam logic [10:0] BAM_FRAC_MUL = 11'd1456;
    localparam logic [10:0] BAM_FRAC_ADD = 11'd1125;
    localparam int          RECIP_SHIFT  = 38;
    localparam longint      RECIP_VAL    = ((64'd1 << RECIP_SHIFT) + 64'd2249) / 64'd2250;
    localparam logic [26:0] RECIP_MUL    = RECIP_VAL[26:0];

    localparam logic [15:0] CDEG_FULL    = 16'd36000;
    localparam logic [15:0] CDEG_90      = 16'd9000;
    localparam logic [15:0] CDEG_180     = 16'd18000;
    localparam logic [15:0] CDEG_270     = 16'd27000;

    typedef struct packed {
        logic signed [15:0] z;
        logic signed [15:0] y;
        logic signed [15:0] x;
    } mag_t;

    typedef struct packed {
        logic signed [31:0] sin_roll;
        logic signed [31:0] cos_roll;
        logic signed [31:0] sin_pitch;
        logic signed [31:0] cos_pitch;
    } trig_t;

    typedef struct packed {
        logic [15:0]        heading;
        logic               hvalid;
        logic signed [17:0] hx;
        logic signed [16:0] hy;
    } res_t;

    // arctan(2^-i) as a binary angle
    function automatic logic [31:0] atan_bam(input int unsigned idx);
        logic [31:0] v;
        case (idx)
            0:       v = 32'h20000000;
            1:       v = 32'h12E4051E;
            2:       v = 32'h09FB385B;
            3:       v = 32'h051111D4;
            4:       v = 32'h028B0D43;
            5:       v = 32'h0145D7E1;
            6:       v = 32'h00A2F61E;
            7:       v = 32'h00517C55;
            8:       v = 32'h0028BE53;
            9:       v = 32'h00145F2F;
            10:      v = 32'h000A2F98;
            11:      v = 32'h000517CC;
            12:      v = 32'h00028BE6;
            13:      v = 32'h000145F3;
            14:      v = 32'h0000A2FA;
            15:      v = 32'h0000517D;
            16:      v = 32'h000028BE;
            17:      v = 32'h0000145F;
            18:      v = 32'h00000A30;
            19:      v = 32'h00000518;
            20:      v = 32'h0000028C;
            21:      v = 32'h00000146;
            22:      v = 32'h000000A3;
            23:      v = 32'h00000051;
            default: v = 32'h00000000;
        endcase
        return v;
    endfunction

endpackage

// ----- src/tcch_sincos.sv -----
// Pipelined angle conversion and rotation CORDIC giving sine and cosine of roll and pitch.
module tcch_sincos (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               en,
    input  logic               in_valid,
    input  logic signed [15:0] in_roll,
    input  logic signed [15:0] in_pitch,
    input  tcch_pkg::mag_t     in_mag,
    output logic               out_valid,
    output tcch_pkg::trig_t    out_trig,
    output tcch_pkg::mag_t     out_mag
);

    localparam int N    = tcch_pkg::ITERS;
    localparam int LAST = N + 4;

    logic           v_reg   [LAST+1];
    tcch_pkg::mag_t mag_reg [LAST+1];

    logic signed [31:0] sin_reg [2];
    logic signed [31:0] cos_reg [2];

    // valid bits and magnetometer sample ride along
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k <= LAST; k++) v_reg[k] <= 1'b0;
        end else if (en) begin
            v_reg[0] <= in_valid;
            for (int k = 1; k <= LAST; k++) v_reg[k] <= v_reg[k-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            mag_reg[0] <= in_mag;
            for (int k = 1; k <= LAST; k++) mag_reg[k] <= mag_reg[k-1];
        end
    end

    for (genvar l = 0; l < 2; l++) begin : g_lane
        logic signed [15:0] ang;
        logic [15:0]        r_reg, r_next;
        logic [31:0]        hi1_reg, hi1_next, hi2_reg;
        logic [25:0]        n_reg, n_next;
        logic [14:0]        lo_reg, lo_next;
        logic signed [31:0] x_reg [N+1];
        logic signed [31:0] y_reg [N+1];
        logic signed [31:0] z_reg [N+1];
        logic               flip_reg [N+1];
        logic signed [31:0] z0_next;
        logic               flip_next;

        if (l == 0) begin : g_roll
            assign ang = in_roll;
        end else begin : g_pitch
            assign ang = in_pitch;
        end

        // wrap to 0..35999, then split the scaling into whole and fraction parts
        always_comb begin
            logic signed [16:0] ext;
            logic signed [16:0] wrapped;
            logic [52:0]        np;
            ext     = {ang[15], ang};
            wrapped = ang[15] ? (ext + 17'sd36000) : ext;
            r_next  = wrapped[15:0];
            hi1_next = 32'(r_reg * tcch_pkg::BAM_WHOLE);
            n_next   = 26'(r_reg * tcch_pkg::BAM_FRAC_MUL + tcch_pkg::BAM_FRAC_ADD);
            np       = 53'(n_reg) * 53'(tcch_pkg::RECIP_MUL);
            lo_next  = np[52:38];
        end

        // fold the left half plane onto the right one
        always_comb begin
            logic [31:0] a;
            logic [31:0] t;
            a         = hi2_reg + 32'(lo_reg);
            t         = a + tcch_pkg::QUARTER_TURN;
            flip_next = t[31];
            z0_next   = $signed(flip_next ? (a + tcch_pkg::HALF_TURN) : a);
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                r_reg       <= r_next;
                hi1_reg     <= hi1_next;
                n_reg       <= n_next;
                hi2_reg     <= hi1_reg;
                lo_reg      <= lo_next;
                x_reg[0]    <= tcch_pkg::GAIN_Q30;
                y_reg[0]    <= 32'sd0;
                z_reg[0]    <= z0_next;
                flip_reg[0] <= flip_next;
            end
        end

        // one micro-rotation per stage
        for (genvar i = 0; i < N; i++) begin : g_iter
            logic signed [31:0] x_next, y_next, z_next;
            always_comb begin
                logic signed [31:0] at;
                at = $signed(tcch_pkg::atan_bam(i));
                if (!z_reg[i][31]) begin
                    x_next = x_reg[i] - (y_reg[i] >>> i);
                    y_next = y_reg[i] + (x_reg[i] >>> i);
                    z_next = z_reg[i] - at;
                end else begin
                    x_next = x_reg[i] + (y_reg[i] >>> i);
                    y_next = y_reg[i] - (x_reg[i] >>> i);
                    z_next = z_reg[i] + at;
                end
            end
            always_ff @(posedge aclk) begin
                if (en) begin
                    x_reg[i+1]    <= x_next;
                    y_reg[i+1]    <= y_next;
                    z_reg[i+1]    <= z_next;
                    flip_reg[i+1] <= flip_reg[i];
                end
            end
        end

        // undo the half-turn fold
        always_ff @(posedge aclk) begin
            if (en) begin
                cos_reg[l] <= flip_reg[N] ? -x_reg[N] : x_reg[N];
                sin_reg[l] <= flip_reg[N] ? -y_reg[N] : y_reg[N];
            end
        end
    end

    assign out_valid          = v_reg[LAST];
    assign out_mag            = mag_reg[LAST];
    assign out_trig.sin_roll  = sin_reg[0];
    assign out_trig.cos_roll  = cos_reg[0];
    assign out_trig.sin_pitch = sin_reg[1];
    assign out_trig.cos_pitch = cos_reg[1];

endmodule

// ----- src/tcch_heading.sv -----
// Pipelined vectoring CORDIC turning the horizontal components into a heading.
module tcch_heading (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               en,
    input  logic               in_valid,
    input  logic signed [17:0] in_hx,
    input  logic signed [16:0] in_hy,
    output logic               out_valid,
    output tcch_pkg::res_t     out_res
);

    localparam int N    = tcch_pkg::ITERS;
    localparam int LAST = N + 2;

    typedef struct packed {
        logic signed [17:0] hx;
        logic signed [16:0] hy;
        logic               zero;
        logic               spec;
        logic [15:0]        spec_val;
    } side_t;

    logic               v_reg    [LAST+1];
    side_t              side_reg [LAST+1];
    logic signed [33:0] vx_reg   [N+1];
    logic signed [33:0] vy_reg   [N+1];
    logic [31:0]        z_reg    [N+1];
    logic [47:0]        prod_reg;
    tcch_pkg::res_t     res_reg, res_next;

    side_t              side_next;
    logic signed [33:0] vx0_next, vy0_next;
    logic [31:0]        z0_next;

    // axis cases, half-plane fold and scaling
    always_comb begin
        logic signed [18:0] x19;
        logic signed [18:0] y19;
        x19 = 19'(in_hx);
        y19 = -19'(in_hy);
        side_next.hx   = in_hx;
        side_next.hy   = in_hy;
        side_next.zero = (in_hx == 18'sd0) && (in_hy == 17'sd0);
        side_next.spec = (in_hx == 18'sd0) || (in_hy == 17'sd0);
        if (in_hy == 17'sd0) begin
            side_next.spec_val = in_hx[17] ? tcch_pkg::CDEG_180 : 16'd0;
        end else begin
            side_next.spec_val = in_hy[16] ? tcch_pkg::CDEG_90 : tcch_pkg::CDEG_270;
        end
        if (in_hx[17]) begin
            x19     = -x19;
            y19     = -y19;
            z0_next = tcch_pkg::HALF_TURN;
        end else begin
            z0_next = 32'd0;
        end
        vx0_next = 34'(x19) <<< 12;
        vy0_next = 34'(y19) <<< 12;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k <= LAST; k++) v_reg[k] <= 1'b0;
        end else if (en) begin
            v_reg[0] <= in_valid;
            for (int k = 1; k <= LAST; k++) v_reg[k] <= v_reg[k-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            side_reg[0] <= side_next;
            for (int k = 1; k <= LAST; k++) side_reg[k] <= side_reg[k-1];
            vx_reg[0] <= vx0_next;
            vy_reg[0] <= vy0_next;
            z_reg[0]  <= z0_next;
        end
    end

    // one vectoring step per stage
    for (genvar i = 0; i < N; i++) begin : g_iter
        logic signed [33:0] vx_next, vy_next;
        logic [31:0]        z_next;
        always_comb begin
            if (!vy_reg[i][33]) begin
                vx_next = vx_reg[i] + (vy_reg[i] >>> i);
                vy_next = vy_reg[i] - (vx_reg[i] >>> i);
                z_next  = z_reg[i] + tcch_pkg::atan_bam(i);
            end else begin
                vx_next = vx_reg[i] - (vy_reg[i] >>> i);
                vy_next = vy_reg[i] + (vx_reg[i] >>> i);
                z_next  = z_reg[i] - tcch_pkg::atan_bam(i);
            end
        end
        always_ff @(posedge aclk) begin
            if (en) begin
                vx_reg[i+1] <= vx_next;
                vy_reg[i+1] <= vy_next;
                z_reg[i+1]  <= z_next;
            end
        end
    end

    // binary angle to centidegrees, then final selection
    always_comb begin
        logic [48:0] sum;
        logic [15:0] h;
        sum = 49'(prod_reg) + 49'(tcch_pkg::HALF_TURN);
        h   = sum[47:32];
        if (h >= tcch_pkg::CDEG_FULL) h = 16'd0;
        res_next.hx     = side_reg[N+1].hx;
        res_next.hy     = side_reg[N+1].hy;
        res_next.hvalid = !side_reg[N+1].zero;
        if (side_reg[N+1].zero) begin
            res_next.heading = 16'd0;
        end else if (side_reg[N+1].spec) begin
            res_next.heading = side_reg[N+1].spec_val;
        end else begin
            res_next.heading = h;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            prod_reg <= 48'(z_reg[N]) * 48'(tcch_pkg::CDEG_FULL);
            res_reg  <= res_next;
        end
    end

    assign out_valid = v_reg[LAST];
    assign out_res   = res_reg;

endmodule

// ----- src/tilt_compensated_compass_heading_unit.sv -----
// Top level of the tilt-compensated compass heading unit.
// One sample enters per clock, unless input is held off: two fully unrolled CORDIC pipelines,
// one for the sine and cosine of roll and pitch and one for the heading angle, lie between
// input and output. The pipeline advances as a whole; a one-entry skid register at the output
// takes a result the sink does not accept, and input is held off only while that register is
// occupied.
module tilt_compensated_compass_heading_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [79:0] s_tdata,   // roll_cdeg, pitch_cdeg, mag_x, mag_y, mag_z
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,   // heading_cdeg, horiz_x, horiz_y, zero fill
    output logic [0:0]  m_tuser    // heading_valid
);

    logic            en;
    logic            sc_valid;
    tcch_pkg::trig_t sc_trig;
    tcch_pkg::mag_t  sc_mag, in_mag;

    logic               q_v_reg [4];
    logic signed [63:0] ss_reg, cs_reg;
    logic signed [31:0] cr1_reg, cp1_reg, sp1_reg;
    tcch_pkg::mag_t     mag1_reg, mag2_reg;
    logic signed [31:0] srsp_reg, cpsr_reg, cr2_reg, cp2_reg, sp2_reg;
    logic signed [47:0] t1_reg, t2_reg, t3_reg, t4_reg, t5_reg;
    logic signed [31:0] srsp_next, cpsr_next;
    logic signed [17:0] hx_reg, hx_next;
    logic signed [16:0] hy_reg, hy_next;

    logic           hd_valid;
    tcch_pkg::res_t hd_res;
    logic           skid_v_reg;
    tcch_pkg::res_t skid_reg, m_res;

    assign en       = !skid_v_reg;
    assign s_tready = en;
    assign in_mag.x = $signed(s_tdata[47:32]);
    assign in_mag.y = $signed(s_tdata[63:48]);
    assign in_mag.z = $signed(s_tdata[79:64]);

    tcch_sincos u_sincos (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (s_tvalid),
        .in_roll   ($signed(s_tdata[15:0])),
        .in_pitch  ($signed(s_tdata[31:16])),
        .in_mag    (in_mag),
        .out_valid (sc_valid),
        .out_trig  (sc_trig),
        .out_mag   (sc_mag)
    );

    // tilt compensation: products, Q30 rounding, weighted sums
    always_comb begin
        logic signed [63:0] a;
        logic signed [63:0] b;
        logic signed [49:0] sx;
        logic signed [49:0] sy;
        a         = ss_reg + (64'sd1 <<< 29);
        b         = cs_reg + (64'sd1 <<< 29);
        srsp_next = a[61:30];
        cpsr_next = b[61:30];
        sx = 50'(t1_reg) + 50'(t2_reg) + 50'(t3_reg) + (50'sd1 <<< 29);
        sy = 50'(t4_reg) - 50'(t5_reg) + (50'sd1 <<< 29);
        sx = sx >>> 30;
        sy = sy >>> 30;
        if (sx > 50'sd131071)       hx_next = 18'sd131071;
        else if (sx < -50'sd131072) hx_next = -18'sd131072;
        else                        hx_next = sx[17:0];
        if (sy > 50'sd65535)        hy_next = 17'sd65535;
        else if (sy < -50'sd65536)  hy_next = -17'sd65536;
        else                        hy_next = sy[16:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < 4; k++) q_v_reg[k] <= 1'b0;
        end else if (en) begin
            q_v_reg[0] <= sc_valid;
            for (int k = 1; k < 4; k++) q_v_reg[k] <= q_v_reg[k-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            ss_reg   <= sc_trig.sin_roll * sc_trig.sin_pitch;
            cs_reg   <= sc_trig.cos_pitch * sc_trig.sin_roll;
            cr1_reg  <= sc_trig.cos_roll;
            cp1_reg  <= sc_trig.cos_pitch;
            sp1_reg  <= sc_trig.sin_pitch;
            mag1_reg <= sc_mag;
            srsp_reg <= srsp_next;
            cpsr_reg <= cpsr_next;
            cr2_reg  <= cr1_reg;
            cp2_reg  <= cp1_reg;
            sp2_reg  <= sp1_reg;
            mag2_reg <= mag1_reg;
            t1_reg   <= mag2_reg.y * srsp_reg;
            t2_reg   <= mag2_reg.x * cr2_reg;
            t3_reg   <= mag2_reg.z * cpsr_reg;
            t4_reg   <= mag2_reg.y * cp2_reg;
            t5_reg   <= mag2_reg.z * sp2_reg;
            hx_reg   <= hx_next;
            hy_reg   <= hy_next;
        end
    end

    tcch_heading u_heading (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (q_v_reg[3]),
        .in_hx     (hx_reg),
        .in_hy     (hy_reg),
        .out_valid (hd_valid),
        .out_res   (hd_res)
    );

    // output skid register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            skid_v_reg <= 1'b0;
        end else if (skid_v_reg) begin
            if (m_tready) skid_v_reg <= 1'b0;
        end else if (hd_valid && !m_tready) begin
            skid_v_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!skid_v_reg && hd_valid && !m_tready) skid_reg <= hd_res;
    end

    assign m_res    = skid_v_reg ? skid_reg : hd_res;
    assign m_tvalid = skid_v_reg || hd_valid;
    assign m_tdata  = {5'd0, m_res.hy, m_res.hx, m_res.heading};
    assign m_tuser  = m_res.hvalid;

`ifndef ASSERT_OFF
    a_invalid_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser[0]) |-> (m_res.heading == 16'd0 && m_res.hx == 18'sd0
                                       && m_res.hy == 17'sd0))
        else $error("invalid heading with nonzero payload");
    a_heading_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_res.heading < tcch_pkg::CDEG_FULL))
        else $error("heading out of range");
    a_skid_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(skid_v_reg) |-> $past(hd_valid && !m_tready))
        else $error("skid register loaded without a stalled result");
`endif

endmodule

// ----- dv/tcch_checker.sv -----
// Checker for the compass heading unit: predicts each result and compares the output stream.
module tcch_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [79:0] s_tdata,   // roll_cdeg, pitch_cdeg, mag_x, mag_y, mag_z
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [55:0] m_tdata,   // heading_cdeg, horiz_x, horiz_y, zero fill
    input  logic [0:0]  m_tuser,   // heading_valid
    output int          fail_count,
    output int          headings_owed
);

    // arctan(2^-i) in binary angle units
    localparam logic [31:0] ARCTAN_STEP [24] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
        32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
    };

    tcch_pkg::res_t heading_q[$];

    // sine and cosine of an angle in centidegrees, Q30
    function automatic void trig_of(input longint cd, output longint s, output longint c);
        longint r, x, y, z, nx, ny;
        logic [31:0] a, t;
        bit flip;
        r = cd % 36000;
        if (r < 0) r += 36000;
        a = 32'((longint'(r) * 64'sd4294967296 + 18000) / 36000);
        t = a + tcch_pkg::QUARTER_TURN;
        flip = (t >= tcch_pkg::HALF_TURN);
        if (flip) a = a + tcch_pkg::HALF_TURN;
        z = (a < tcch_pkg::HALF_TURN) ? longint'({32'b0, a})
                                      : longint'({32'b0, a}) - 64'sd4294967296;
        x = tcch_pkg::GAIN_Q30;
        y = 0;
        for (int i = 0; i < tcch_pkg::ITERS; i++) begin
            if (z >= 0) begin
                nx = x - (y >>> i);
                ny = y + (x >>> i);
                z -= longint'({32'b0, ARCTAN_STEP[i]});
            end else begin
                nx = x + (y >>> i);
                ny = y - (x >>> i);
                z += longint'({32'b0, ARCTAN_STEP[i]});
            end
            x = nx;
            y = ny;
        end
        c = flip ? -x : x;
        s = flip ? -y : y;
    endfunction

    function automatic longint round_q30(input longint p);
        return (p + (64'sd1 <<< 29)) >>> 30;
    endfunction

    // heading angle of the horizontal vector, centidegrees
    function automatic logic [15:0] angle_of(input longint hx, input longint hy);
        longint vx, vy, nx, ny;
        logic [31:0] z;
        logic [63:0] h;
        if (hy == 0) return (hx > 0) ? 16'd0 : tcch_pkg::CDEG_180;
        if (hx == 0) return (hy < 0) ? tcch_pkg::CDEG_90 : tcch_pkg::CDEG_270;
        vx = hx;
        vy = -hy;
        z = '0;
        if (vx < 0) begin
            vx = -vx;
            vy = -vy;
            z = tcch_pkg::HALF_TURN;
        end
        vx *= 4096;
        vy *= 4096;
        for (int i = 0; i < tcch_pkg::ITERS; i++) begin
            if (vy >= 0) begin
                nx = vx + (vy >>> i);
                ny = vy - (vx >>> i);
                z = z + ARCTAN_STEP[i];
            end else begin
                nx = vx - (vy >>> i);
                ny = vy + (vx >>> i);
                z = z - ARCTAN_STEP[i];
            end
            vx = nx;
            vy = ny;
        end
        h = ({32'b0, z} * 64'd36000 + 64'h8000_0000) >> 32;
        if (h >= 64'd36000) h = 0;
        return h[15:0];
    endfunction

    function automatic tcch_pkg::res_t predict_heading(input logic [79:0] d);
        longint roll, pitch, mx, my, mz, sr, cr, sp, cp, srsp, cpsr, hx, hy;
        tcch_pkg::res_t r;
        roll  = longint'($signed(d[15:0]));
        pitch = longint'($signed(d[31:16]));
        mx    = longint'($signed(d[47:32]));
        my    = longint'($signed(d[63:48]));
        mz    = longint'($signed(d[79:64]));
        trig_of(roll, sr, cr);
        trig_of(pitch, sp, cp);
        srsp = round_q30(sr * sp);
        cpsr = round_q30(cp * sr);
        hx = round_q30(my * srsp + mx * cr + mz * cpsr);
        hy = round_q30(my * cp - mz * sp);
        if (hx < -131072) hx = -131072;
        if (hx > 131071)  hx = 131071;
        if (hy < -65536)  hy = -65536;
        if (hy > 65535)   hy = 65535;
        r.hx = hx[17:0];
        r.hy = hy[16:0];
        r.hvalid = (hx != 0 || hy != 0);
        r.heading = r.hvalid ? angle_of(hx, hy) : 16'd0;
        return r;
    endfunction

    // sample both channels at the edge; values read here are the pre-edge ones
    always @(posedge aclk) begin
        tcch_pkg::res_t e;
        int errs;
        errs = 0;
        if (!aresetn) begin
            heading_q.delete();
            fail_count    <= 0;
            headings_owed <= 0;
        end else begin
            if (s_tvalid && s_tready)
                heading_q.push_back(predict_heading(s_tdata));
            if (m_tvalid && m_tready) begin
                if (heading_q.size() == 0) begin
                    $error("result transfer with nothing expected: %h", m_tdata);
                    errs = errs + 1;
                end else begin
                    e = heading_q.pop_front();
                    if (m_tdata[15:0] !== e.heading) begin
                        $error("heading_cdeg expected %0d actual %0d", e.heading, m_tdata[15:0]);
                        errs = errs + 1;
                    end
                    if (m_tuser[0] !== e.hvalid) begin
                        $error("heading_valid expected %0d actual %0d", e.hvalid, m_tuser[0]);
                        errs = errs + 1;
                    end
                    if (m_tdata[33:16] !== e.hx) begin
                        $error("horiz_x expected %0d actual %0d",
                               $signed(e.hx), $signed(m_tdata[33:16]));
                        errs = errs + 1;
                    end
                    if (m_tdata[50:34] !== e.hy) begin
                        $error("horiz_y expected %0d actual %0d",
                               $signed(e.hy), $signed(m_tdata[50:34]));
                        errs = errs + 1;
                    end
                end
            end
            fail_count    <= fail_count + errs;
            headings_owed <= heading_q.size();
        end
    end

endmodule

// ----- dv/tb_tilt_compensated_compass_heading_unit.sv -----
// Testbench top for the compass heading unit: stimulus, output stalls and verdict.
module tb_tilt_compensated_compass_heading_unit;

    localparam int RANDOM_SAMPLES = 530;
    localparam int CYCLE_LIMIT    = 200000;
    localparam int DRAIN_CYCLES   = 2 * tcch_pkg::ITERS + 20;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [79:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [55:0] m_tdata;
    logic [0:0]  m_tuser;
    int          fail_count;
    int          headings_owed;
    int          cycle_count = 0;
    bit          sample_burst = 0;
    bit          sink_burst = 0;

    tilt_compensated_compass_heading_unit dut (.*);

    tcch_checker u_checker (.*);

    initial begin
        forever #2 aclk = ~aclk;
    end

    // run limit
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // one sample transfer, after a random gap unless in a burst stretch
    task automatic send_sample(input logic signed [15:0] roll, input logic signed [15:0] pitch,
                               input logic signed [15:0] mx, input logic signed [15:0] my,
                               input logic signed [15:0] mz);
        int gap;
        gap = sample_burst ? 0 : $urandom_range(0, 13);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {mz, my, mx, pitch, roll};
        do @(posedge aclk); while (!s_tready);
    endtask

    function automatic logic [15:0] any_angle();
        return (($urandom_range(0, 3) == 0) ? 16'($urandom)
                                            : 16'($signed($urandom_range(0, 36000)) - 18000));
    endfunction

    // result side: random stall per result
    initial begin
        int hold;
        @(posedge aresetn);
        forever begin
            hold = sink_burst ? 0 : $urandom_range(0, 13);
            if (hold > 0) begin
                m_tready <= 1'b0;
                repeat (hold) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
        end
    end

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: zero field, axis cases, extremes and wrapped angles
        send_sample(0, 0, 0, 0, 0);
        send_sample(0, 0, 1000, 0, 0);
        send_sample(0, 0, -1000, 0, 0);
        send_sample(0, 0, 0, 1000, 0);
        send_sample(0, 0, 0, -1000, 0);
        send_sample(0, 0, 32767, 32767, 32767);
        send_sample(0, 0, -32768, -32768, -32768);
        send_sample(18000, 18000, 32767, -32768, 32767);
        send_sample(-18000, -18000, -32768, 32767, -32768);
        send_sample(9000, 9000, 1, 1, 1);
        send_sample(-9000, 4500, 500, -700, 300);
        send_sample(27000, -27000, 1234, 4321, -999);
        send_sample(32767, -32768, 32767, 32767, -32768);
        send_sample(-32768, 32767, -32768, -32768, 32767);
        send_sample(36000, -36000, 100, 100, 100);
        send_sample(0, 0, 1, 0, 0);
        send_sample(0, 0, -1, -1, 0);
        send_sample(17999, -17999, 0, 0, 32767);
        send_sample(0, 0, 20000, 1, 0);
        send_sample(0, 0, 20000, -1, 0);

        // random: mostly arbitrary attitudes, some near-zero fields, some full-width noise, bursts mixed in
        for (int n = 0; n < RANDOM_SAMPLES; n++) begin
            if (n % 60 == 0) begin
                sample_burst = ($urandom_range(0, 2) == 0);
                sink_burst   = ($urandom_range(0, 2) == 0);
            end
            case ($urandom_range(0, 5))
                0: send_sample(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                               16'($urandom));
                1: send_sample(any_angle(), any_angle(), 16'($signed($urandom_range(0, 8)) - 4),
                               16'($signed($urandom_range(0, 8)) - 4),
                               16'($signed($urandom_range(0, 8)) - 4));
                default: send_sample(any_angle(), any_angle(), 16'($urandom), 16'($urandom),
                                     16'($urandom));
            endcase
        end
        s_tvalid <= 1'b0;
        sink_burst = 0;

        // drain; the owed count is registered, so it settles after the last transfer
        @(posedge aclk);
        while (headings_owed != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
